// ----- hdl/ufcb_pkg.sv -----
// ----------------------------------------------------------------------------
// ufcb_pkg
// shared codes, characters and the result record of the uart flow control queues
// ----------------------------------------------------------------------------
package ufcb_pkg;

	// event codes on the mode field
	localparam logic [2:0] MODE_LINE_RX = 3'd0;
	localparam logic [2:0] MODE_HOST_WR = 3'd1;
	localparam logic [2:0] MODE_HOST_RD = 3'd2;
	localparam logic [2:0] MODE_CTS     = 3'd3;
	localparam logic [2:0] MODE_TX_FREE = 3'd4;

	// in-band flow control characters
	localparam logic [7:0] CHAR_XOFF = 8'd19;
	localparam logic [7:0] CHAR_XON  = 8'd17;

	// register indexes on the apb port
	typedef enum logic [1:0] {
		REG_XON_XOFF_EN = 2'd0,
		REG_RTS_CTS_EN  = 2'd1,
		REG_HIGH_WATER  = 2'd2,
		REG_LOW_WATER   = 2'd3
	} reg_idx_t;

	localparam logic [8:0] HIGH_WATER_RST = 9'd204;
	localparam logic [8:0] LOW_WATER_RST  = 9'd51;

	// one result beat, less the bytes that come out of the queue rams
	typedef struct packed {
		logic       tx_valid;
		logic       tx_xoff;
		logic       tx_ram;
		logic       rts_level;
		logic       read_valid;
		logic       underflow;
		logic       write_full;
		logic       rx_overflow;
		logic       output_blocked;
		logic       input_blocked;
		logic [8:0] rx_count;
	} ufcb_res_t;

endpackage

// ----- hdl/ufcb_ram.sv -----
// ----------------------------------------------------------------------------
// ufcb_ram
// single port write, single port read ram with registered read data
// ----------------------------------------------------------------------------
module ufcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/uart_flow_control_buffers.sv -----
// ----------------------------------------------------------------------------
// uart_flow_control_buffers
// receive and transmit byte queues joined by xon/xoff and rts/cts flow control
// ----------------------------------------------------------------------------
//
//  channel   | handshake                    | beat
//  ----------+------------------------------+----------------------------------------
//  in        | in_valid / in_ready          | mode, data_byte, cts_level
//  out       | out_valid / out_ready        | tx_valid .. rx_count, one per in beat
//  apb       | psel, penable, pwrite, pready| paddr, pwdata, prdata (4 registers)
//
//  one event is taken per cycle while in_ready is high; state and the queue
//  ram read update at the accepting edge, s1 holds the status meanwhile, and
//  the output register merges in the ram bytes as it takes the s1 beat, so
//  the result beat passes through s1 and then the output register
//  the queue rams are not cleared at reset: an entry is read only after the
//  fill count shows it written, so no clearing pass is needed
//  a stalled out channel holds one beat in the output register and one in
//  the s1 stage, after which in_ready drops
//
module uart_flow_control_buffers #(
	parameter int RX_DEPTH = 256,
	parameter int TX_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// event beats
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [7:0]  data_byte,
	input  logic        cts_level,
	// result beats
	output logic        out_valid,
	input  logic        out_ready,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        rts_level,
	output logic        read_valid,
	output logic [7:0]  read_byte,
	output logic        underflow,
	output logic        write_full,
	output logic        rx_overflow,
	output logic        output_blocked,
	output logic        input_blocked,
	output logic [8:0]  rx_count
);

	import ufcb_pkg::*;

	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam int RX_FW = $clog2(RX_DEPTH + 1);
	localparam int TX_FW = $clog2(TX_DEPTH + 1);
	// compare width for fill count against the 9-bit water marks
	localparam int CMPW  = (RX_FW > 9) ? RX_FW : 9;

	// ------------------------------------------------------------------
	// state registers
	// ------------------------------------------------------------------
	logic             xon_xoff_en_q, rts_cts_en_q;
	logic [8:0]       high_water_q, low_water_q;
	logic [RX_AW-1:0] rx_head_q, rx_tail_q;
	logic [RX_FW-1:0] rx_fill_q;
	logic [TX_AW-1:0] tx_head_q, tx_tail_q;
	logic [TX_FW-1:0] tx_fill_q;
	logic             held_by_xoff_q, held_by_cts_q, remote_stopped_q;
	logic             xoff_pending_q, rts_out_q;
	logic             stop_via_xoff_q, stop_via_rts_q, cts_seen_q;

	// next state for an accepted event
	logic [RX_AW-1:0] rx_head_nx, rx_tail_nx;
	logic [RX_FW-1:0] rx_fill_nx;
	logic [TX_AW-1:0] tx_head_nx, tx_tail_nx;
	logic [TX_FW-1:0] tx_fill_nx;
	logic             held_by_xoff_nx, held_by_cts_nx, remote_stopped_nx;
	logic             xoff_pending_nx, rts_out_nx;
	logic             stop_via_xoff_nx, stop_via_rts_nx, cts_seen_nx;
	ufcb_res_t        res;

	// queue ram controls
	logic             rx_wr, rx_rd, tx_wr, tx_rd, push_xon;
	logic [7:0]       tx_wdata;
	logic [7:0]       rx_rdata, tx_rdata;

	// pipeline
	logic             in_accept, out_free;
	logic             v_s1;
	ufcb_res_t        res_s1;
	logic             out_valid_q;
	ufcb_res_t        out_res_q;
	logic [7:0]       tx_byte_q, read_byte_q;

	// apb
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_comb begin
		case (cfg_idx)
			REG_XON_XOFF_EN: prdata = {31'd0, xon_xoff_en_q};
			REG_RTS_CTS_EN:  prdata = {31'd0, rts_cts_en_q};
			REG_HIGH_WATER:  prdata = {23'd0, high_water_q};
			REG_LOW_WATER:   prdata = {23'd0, low_water_q};
			default:         prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// event handshake: s1 frees when its beat moves to the output register
	// ------------------------------------------------------------------
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = !v_s1 || out_free;
	assign in_accept = in_valid && in_ready;

	// ------------------------------------------------------------------
	// event decode and next state
	// ------------------------------------------------------------------
	logic             rx_full, tx_full;
	logic [RX_AW-1:0] rx_tail_inc, rx_head_inc;
	logic [TX_AW-1:0] tx_tail_inc, tx_head_inc;
	logic [RX_FW-1:0] rx_fill_up, rx_fill_dn;

	assign rx_full     = (rx_fill_q == RX_FW'(RX_DEPTH));
	assign tx_full     = (tx_fill_q == TX_FW'(TX_DEPTH));
	assign rx_tail_inc = (rx_tail_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail_q + 1'b1;
	assign rx_head_inc = (rx_head_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_q + 1'b1;
	assign tx_tail_inc = (tx_tail_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail_q + 1'b1;
	assign tx_head_inc = (tx_head_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_q + 1'b1;
	assign rx_fill_up  = rx_fill_q + 1'b1;
	assign rx_fill_dn  = rx_fill_q - 1'b1;

	always_comb begin
		rx_head_nx        = rx_head_q;
		rx_tail_nx        = rx_tail_q;
		rx_fill_nx        = rx_fill_q;
		tx_head_nx        = tx_head_q;
		tx_tail_nx        = tx_tail_q;
		tx_fill_nx        = tx_fill_q;
		held_by_xoff_nx   = held_by_xoff_q;
		held_by_cts_nx    = held_by_cts_q;
		remote_stopped_nx = remote_stopped_q;
		xoff_pending_nx   = xoff_pending_q;
		rts_out_nx        = rts_out_q;
		stop_via_xoff_nx  = stop_via_xoff_q;
		stop_via_rts_nx   = stop_via_rts_q;
		cts_seen_nx       = cts_seen_q;
		rx_wr             = 1'b0;
		rx_rd             = 1'b0;
		tx_wr             = 1'b0;
		tx_rd             = 1'b0;
		push_xon          = 1'b0;
		res               = '0;

		case (mode)
			MODE_LINE_RX: begin
				if (xon_xoff_en_q && data_byte == CHAR_XON) begin
					held_by_xoff_nx = 1'b0;
				end else if (xon_xoff_en_q && data_byte == CHAR_XOFF) begin
					held_by_xoff_nx = 1'b1;
				end else if (rx_full) begin
					res.rx_overflow = 1'b1;
				end else begin
					rx_wr      = 1'b1;
					rx_tail_nx = rx_tail_inc;
					rx_fill_nx = rx_fill_up;
					// high-water hit: tell the partner to stop
					if (CMPW'(rx_fill_up) == CMPW'(high_water_q)) begin
						if (xon_xoff_en_q) begin
							xoff_pending_nx   = 1'b1;
							stop_via_xoff_nx  = 1'b1;
							remote_stopped_nx = 1'b1;
						end
						if (rts_cts_en_q) begin
							rts_out_nx        = 1'b0;
							stop_via_rts_nx   = 1'b1;
							remote_stopped_nx = 1'b1;
						end
					end
				end
			end
			MODE_HOST_WR: begin
				if (tx_full) begin
					res.write_full = 1'b1;
				end else begin
					tx_wr      = 1'b1;
					tx_tail_nx = tx_tail_inc;
					tx_fill_nx = tx_fill_q + 1'b1;
				end
			end
			MODE_HOST_RD: begin
				if (rx_fill_q == '0) begin
					res.underflow = 1'b1;
				end else begin
					rx_rd          = 1'b1;
					res.read_valid = 1'b1;
					rx_head_nx     = rx_head_inc;
					rx_fill_nx     = rx_fill_dn;
					// low-water release of a stopped partner
					if (CMPW'(rx_fill_dn) == CMPW'(low_water_q) && remote_stopped_q) begin
						if (xon_xoff_en_q && !tx_full) begin
							tx_wr      = 1'b1;
							push_xon   = 1'b1;
							tx_tail_nx = tx_tail_inc;
							tx_fill_nx = tx_fill_q + 1'b1;
						end
						if (rts_cts_en_q) begin
							rts_out_nx = 1'b1;
						end
						remote_stopped_nx = 1'b0;
						stop_via_xoff_nx  = 1'b0;
						stop_via_rts_nx   = 1'b0;
					end
				end
			end
			MODE_CTS: begin
				cts_seen_nx = cts_level;
				if (rts_cts_en_q) begin
					held_by_cts_nx = !cts_level;
				end
			end
			MODE_TX_FREE: begin
				// a pending xoff goes out ahead of data, even while held
				if (xoff_pending_q) begin
					xoff_pending_nx = 1'b0;
					res.tx_valid    = 1'b1;
					res.tx_xoff     = 1'b1;
				end else if (!held_by_xoff_q && !held_by_cts_q && tx_fill_q != '0) begin
					tx_rd        = 1'b1;
					res.tx_valid = 1'b1;
					res.tx_ram   = 1'b1;
					tx_head_nx   = tx_head_inc;
					tx_fill_nx   = tx_fill_q - 1'b1;
				end
			end
			default: begin
			end
		endcase

		res.rts_level      = rts_out_nx;
		res.output_blocked = held_by_xoff_nx || held_by_cts_nx;
		res.input_blocked  = remote_stopped_nx;
		res.rx_count       = 9'(rx_fill_nx);
	end

	assign tx_wdata = push_xon ? CHAR_XON : data_byte;

	// ------------------------------------------------------------------
	// queue rams
	// ------------------------------------------------------------------
	ufcb_ram #(
		.WIDTH (8),
		.DEPTH (RX_DEPTH)
	) u_rx_ram (
		.clk   (clk),
		.we    (in_accept && rx_wr),
		.waddr (rx_tail_q),
		.wdata (data_byte),
		.re    (in_accept && rx_rd),
		.raddr (rx_head_q),
		.rdata (rx_rdata)
	);

	ufcb_ram #(
		.WIDTH (8),
		.DEPTH (TX_DEPTH)
	) u_tx_ram (
		.clk   (clk),
		.we    (in_accept && tx_wr),
		.waddr (tx_tail_q),
		.wdata (tx_wdata),
		.re    (in_accept && tx_rd),
		.raddr (tx_head_q),
		.rdata (tx_rdata)
	);

	// ------------------------------------------------------------------
	// flow control state and configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xon_xoff_en_q    <= 1'b0;
			rts_cts_en_q     <= 1'b0;
			high_water_q     <= HIGH_WATER_RST;
			low_water_q      <= LOW_WATER_RST;
			rx_head_q        <= '0;
			rx_tail_q        <= '0;
			rx_fill_q        <= '0;
			tx_head_q        <= '0;
			tx_tail_q        <= '0;
			tx_fill_q        <= '0;
			held_by_xoff_q   <= 1'b0;
			held_by_cts_q    <= 1'b0;
			remote_stopped_q <= 1'b0;
			xoff_pending_q   <= 1'b0;
			rts_out_q        <= 1'b1;
			stop_via_xoff_q  <= 1'b0;
			stop_via_rts_q   <= 1'b0;
			cts_seen_q       <= 1'b1;
		end else if (cfg_wr) begin
			// register writes must come only while no event is in flight; the block does not enforce it
			case (cfg_idx)
				REG_XON_XOFF_EN: begin
					xon_xoff_en_q <= pwdata[0];
					if (!pwdata[0]) begin
						held_by_xoff_q   <= 1'b0;
						stop_via_xoff_q  <= 1'b0;
						xoff_pending_q   <= 1'b0;
						remote_stopped_q <= stop_via_rts_q;
					end
				end
				REG_RTS_CTS_EN: begin
					rts_cts_en_q <= pwdata[0];
					if (!pwdata[0]) begin
						held_by_cts_q    <= 1'b0;
						rts_out_q        <= 1'b1;
						stop_via_rts_q   <= 1'b0;
						remote_stopped_q <= stop_via_xoff_q;
					end else begin
						held_by_cts_q <= !cts_seen_q;
						if (CMPW'(rx_fill_q) < CMPW'(high_water_q)) begin
							rts_out_q <= 1'b1;
						end else begin
							rts_out_q        <= 1'b0;
							stop_via_rts_q   <= 1'b1;
							remote_stopped_q <= 1'b1;
						end
					end
				end
				REG_HIGH_WATER: begin
					high_water_q <= pwdata[8:0];
				end
				REG_LOW_WATER: begin
					low_water_q <= pwdata[8:0];
				end
				default: begin
				end
			endcase
		end else if (in_accept) begin
			rx_head_q        <= rx_head_nx;
			rx_tail_q        <= rx_tail_nx;
			rx_fill_q        <= rx_fill_nx;
			tx_head_q        <= tx_head_nx;
			tx_tail_q        <= tx_tail_nx;
			tx_fill_q        <= tx_fill_nx;
			held_by_xoff_q   <= held_by_xoff_nx;
			held_by_cts_q    <= held_by_cts_nx;
			remote_stopped_q <= remote_stopped_nx;
			xoff_pending_q   <= xoff_pending_nx;
			rts_out_q        <= rts_out_nx;
			stop_via_xoff_q  <= stop_via_xoff_nx;
			stop_via_rts_q   <= stop_via_rts_nx;
			cts_seen_q       <= cts_seen_nx;
		end
	end

	// ------------------------------------------------------------------
	// s1 waits on the ram read; the output register merges the bytes in
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				v_s1 <= 1'b1;
			end else if (out_free) begin
				v_s1 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_s1 <= res;
		end
		// ram read data holds until the next read, so a waiting s1 still sees it
		if (out_free && v_s1) begin
			out_res_q   <= res_s1;
			tx_byte_q   <= res_s1.tx_ram ? tx_rdata :
			               (res_s1.tx_xoff ? CHAR_XOFF : 8'd0);
			read_byte_q <= res_s1.read_valid ? rx_rdata : 8'd0;
		end
	end

	assign out_valid      = out_valid_q;
	assign tx_valid       = out_res_q.tx_valid;
	assign tx_byte        = tx_byte_q;
	assign rts_level      = out_res_q.rts_level;
	assign read_valid     = out_res_q.read_valid;
	assign read_byte      = read_byte_q;
	assign underflow      = out_res_q.underflow;
	assign write_full     = out_res_q.write_full;
	assign rx_overflow    = out_res_q.rx_overflow;
	assign output_blocked = out_res_q.output_blocked;
	assign input_blocked  = out_res_q.input_blocked;
	assign rx_count       = out_res_q.rx_count;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_rx_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rx_fill_q <= RX_FW'(RX_DEPTH))
		else $error("receive fill above depth");

	a_tx_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tx_fill_q <= TX_FW'(TX_DEPTH))
		else $error("transmit fill above depth");

	a_rx_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_fill_q == '0) |-> (rx_head_q == rx_tail_q))
		else $error("empty receive queue with unequal pointers");

	a_read_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_res_q.read_valid && out_res_q.underflow))
		else $error("read beat both valid and underflow");

	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !out_valid_q) |=> out_valid_q)
		else $error("s1 beat not moved to output register");

endmodule

// ----- test/uart_flow_control_buffers_tb.sv -----
// ----------------------------------------------------------------------------
// uart_flow_control_buffers_tb
// self-checking bench for the uart receive/transmit queues with flow control
//
// events go in on a valid/ready channel and every one of them yields one
// status beat on the result channel. a behavioral copy of the queues and the
// xon/xoff and rts/cts state predicts each beat at the moment its event is
// accepted; the result side compares every beat against the oldest
// prediction. a short directed table opens the run, then phases of random
// events under changing apb settings push the queues through fill, overflow,
// drain, underflow and the watermark transitions.
// ----------------------------------------------------------------------------
module uart_flow_control_buffers_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ufcb_pkg::*;

	// queue sizes of the instance under test
	localparam int RX_CAP = 256;
	localparam int TX_CAP = 256;

	// mode codes that the block ignores
	localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
	localparam logic [2:0] MODE_SPARE_MID = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

	localparam int ITEM_TARGET = 1400;
	localparam int HOLD_CYCLES = 150;
	localparam int DIR_ROWS    = 31;

	// one result beat as seen on the output ports
	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       rts_level;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       underflow;
		logic       write_full;
		logic       rx_overflow;
		logic       output_blocked;
		logic       input_blocked;
		logic [8:0] rx_count;
	} uart_beat_t;

	// one row of the directed table: either a register write or an event
	typedef struct {
		logic       is_reg;
		reg_idx_t   ridx;
		logic [8:0] rval;
		logic [2:0] md;
		logic [7:0] db;
		logic       cl;
		logic       known;
		uart_beat_t want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  mode;
	logic [7:0]  data_byte;
	logic        cts_level;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        rts_level;
	logic        read_valid;
	logic [7:0]  read_byte;
	logic        underflow;
	logic        write_full;
	logic        rx_overflow;
	logic        output_blocked;
	logic        input_blocked;
	logic [8:0]  rx_count;

	// predicted beats, oldest first
	uart_beat_t due_status [$];

	// shadow of the block: queue contents, flow control flags and settings
	logic [7:0] rx_fifo [$];
	logic [7:0] tx_fifo [$];
	logic       en_xon      = 1'b0;
	logic       en_rts      = 1'b0;
	logic [8:0] hw_mark     = HIGH_WATER_RST;
	logic [8:0] lw_mark     = LOW_WATER_RST;
	logic       hold_xoff   = 1'b0;
	logic       hold_cts    = 1'b0;
	logic       far_stopped = 1'b0;
	logic       xoff_due    = 1'b0;
	logic       rts_q       = 1'b1;
	logic       why_xoff    = 1'b0;
	logic       why_rts     = 1'b0;
	logic       last_cts    = 1'b1;

	int fault_count = 0;
	int items_sent  = 0;
	int burst_left  = 0;
	// long receiver hold-offs asked by the stimulus and served by the sink
	int hold_asks   = 0;
	int holds_done  = 0;
	int hold_left   = 0;
	int seg_left    = 0;
	logic seg_on    = 1'b0;

	dir_row_t dir_tab [DIR_ROWS];

	uart_flow_control_buffers #(
		.RX_DEPTH(RX_CAP),
		.TX_DEPTH(TX_CAP)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.data_byte     (data_byte),
		.cts_level     (cts_level),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.tx_valid      (tx_valid),
		.tx_byte       (tx_byte),
		.rts_level     (rts_level),
		.read_valid    (read_valid),
		.read_byte     (read_byte),
		.underflow     (underflow),
		.write_full    (write_full),
		.rx_overflow   (rx_overflow),
		.output_blocked(output_blocked),
		.input_blocked (input_blocked),
		.rx_count      (rx_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// generous ceiling on the whole run
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// settle a register write into the shadow state
	function automatic void cfg_apply(input reg_idx_t idx, input logic [8:0] v);
		case (idx)
			REG_XON_XOFF_EN: begin
				en_xon = v[0];
				// turning in-band control off drops every xoff effect
				if (!en_xon) begin
					hold_xoff   = 1'b0;
					why_xoff    = 1'b0;
					xoff_due    = 1'b0;
					far_stopped = why_rts;
				end
			end
			REG_RTS_CTS_EN: begin
				en_rts = v[0];
				if (!en_rts) begin
					hold_cts    = 1'b0;
					rts_q       = 1'b1;
					why_rts     = 1'b0;
					far_stopped = why_xoff;
				end else begin
					// cts hold picks up the last level seen on the line
					hold_cts = !last_cts;
					if (rx_fifo.size() < hw_mark) begin
						rts_q = 1'b1;
					end else begin
						rts_q       = 1'b0;
						why_rts     = 1'b1;
						far_stopped = 1'b1;
					end
				end
			end
			REG_HIGH_WATER: hw_mark = v;
			REG_LOW_WATER:  lw_mark = v;
			default: ;
		endcase
	endfunction

	// advance the shadow by one event and return the beat it causes
	function automatic uart_beat_t flow_step(input logic [2:0] md, input logic [7:0] db,
			input logic cl);
		uart_beat_t b;
		b = '0;
		case (md)
			MODE_LINE_RX: begin
				if (en_xon && db == CHAR_XON) begin
					hold_xoff = 1'b0;
				end else if (en_xon && db == CHAR_XOFF) begin
					hold_xoff = 1'b1;
				end else if (rx_fifo.size() >= RX_CAP) begin
					// full queue drops the byte, no watermark check
					b.rx_overflow = 1'b1;
				end else begin
					rx_fifo.push_back(db);
					if (rx_fifo.size() == hw_mark) begin
						if (en_xon) begin
							xoff_due    = 1'b1;
							why_xoff    = 1'b1;
							far_stopped = 1'b1;
						end
						if (en_rts) begin
							rts_q       = 1'b0;
							why_rts     = 1'b1;
							far_stopped = 1'b1;
						end
					end
				end
			end
			MODE_HOST_WR: begin
				if (tx_fifo.size() >= TX_CAP)
					b.write_full = 1'b1;
				else
					tx_fifo.push_back(db);
			end
			MODE_HOST_RD: begin
				if (rx_fifo.size() == 0) begin
					b.underflow = 1'b1;
				end else begin
					b.read_byte  = rx_fifo.pop_front();
					b.read_valid = 1'b1;
					if (rx_fifo.size() == lw_mark && far_stopped) begin
						// xon is lost when the transmit queue has no room
						if (en_xon && tx_fifo.size() < TX_CAP)
							tx_fifo.push_back(CHAR_XON);
						if (en_rts)
							rts_q = 1'b1;
						far_stopped = 1'b0;
						why_xoff    = 1'b0;
						why_rts     = 1'b0;
					end
				end
			end
			MODE_CTS: begin
				last_cts = cl;
				if (en_rts)
					hold_cts = !cl;
			end
			MODE_TX_FREE: begin
				// a pending xoff goes out even while output is held
				if (xoff_due) begin
					xoff_due   = 1'b0;
					b.tx_valid = 1'b1;
					b.tx_byte  = CHAR_XOFF;
				end else if (!hold_xoff && !hold_cts && tx_fifo.size() > 0) begin
					b.tx_byte  = tx_fifo.pop_front();
					b.tx_valid = 1'b1;
				end
			end
			default: ;
		endcase
		b.rts_level      = rts_q;
		b.output_blocked = hold_xoff | hold_cts;
		b.input_blocked  = far_stopped;
		b.rx_count       = 9'(rx_fifo.size());
		return b;
	endfunction

	// ------------------------------------------------------------------
	// directed table helpers
	// ------------------------------------------------------------------

	function automatic uart_beat_t status_of(input logic txv, input logic [7:0] txb,
			input logic rts, input logic rdv, input logic [7:0] rdb, input logic unf,
			input logic wfl, input logic ovf, input logic obl, input logic ibl,
			input logic [8:0] cnt);
		return {txv, txb, rts, rdv, rdb, unf, wfl, ovf, obl, ibl, cnt};
	endfunction

	// event whose beat is typed in the table
	function automatic dir_row_t ev_known(input logic [2:0] md, input logic [7:0] db,
			input logic cl, input uart_beat_t want);
		dir_row_t r;
		r = '{is_reg: 1'b0, ridx: REG_XON_XOFF_EN, rval: '0, md: md, db: db, cl: cl,
			known: 1'b1, want: want};
		return r;
	endfunction

	// event whose beat comes from the predictor
	function automatic dir_row_t ev_model(input logic [2:0] md, input logic [7:0] db,
			input logic cl);
		dir_row_t r;
		r = '{is_reg: 1'b0, ridx: REG_XON_XOFF_EN, rval: '0, md: md, db: db, cl: cl,
			known: 1'b0, want: '0};
		return r;
	endfunction

	function automatic dir_row_t reg_row(input reg_idx_t idx, input logic [8:0] v);
		dir_row_t r;
		r = '{is_reg: 1'b1, ridx: idx, rval: v, md: '0, db: '0, cl: 1'b0,
			known: 1'b0, want: '0};
		return r;
	endfunction

	function automatic string beat_str(input uart_beat_t b);
		return $sformatf({"txv=%0b txb=%02h rts=%0b rdv=%0b rdb=%02h unf=%0b wfull=%0b ",
			"ovf=%0b oblk=%0b iblk=%0b cnt=%0d"}, b.tx_valid, b.tx_byte, b.rts_level,
			b.read_valid, b.read_byte, b.underflow, b.write_full, b.rx_overflow,
			b.output_blocked, b.input_blocked, b.rx_count);
	endfunction

	// ------------------------------------------------------------------
	// drivers, all entered and left at a falling edge
	// ------------------------------------------------------------------

	// offer one event beat; bursts of back-to-back beats with random gaps.
	// on return the caller owns in_valid in the current time step
	task automatic send_event(input logic [2:0] md, input logic [7:0] db, input logic cl,
			input logic known, input uart_beat_t want);
		int gap;
		uart_beat_t pred;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid  = 1'b1;
		mode      = md;
		data_byte = db;
		cts_level = cl;
		do @(posedge clk); while (!in_ready);
		// beat taken at this edge: predict now, in acceptance order
		pred = flow_step(md, db, cl);
		due_status.push_back(known ? want : pred);
		items_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	// stop offering and wait until every predicted beat has come back
	task automatic drain_wait();
		in_valid = 1'b0;
		while (due_status.size() != 0) @(negedge clk);
	endtask

	// apb write: setup cycle, access cycle, then the bus goes idle
	task automatic reg_write(input reg_idx_t idx, input logic [8:0] v);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = {23'd0, v};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		cfg_apply(idx, v);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
	endtask

	// full settings change while the block is idle; the watermarks go first
	// so that enabling rts/cts sees the new high-water mark
	task automatic set_config(input logic xx, input logic rc, input logic [8:0] hw,
			input logic [8:0] lw);
		drain_wait();
		reg_write(REG_HIGH_WATER, hw);
		reg_write(REG_LOW_WATER, lw);
		reg_write(REG_XON_XOFF_EN, {8'd0, xx});
		reg_write(REG_RTS_CTS_EN, {8'd0, rc});
	endtask

	// mostly small marks so that watermark crossings are frequent,
	// with the extremes now and then
	function automatic logic [8:0] pick_high();
		case ($urandom_range(0, 9))
			0:       return 9'd0;
			1:       return 9'd256;
			2:       return 9'd255;
			3:       return 9'd1;
			default: return 9'($urandom_range(2, 24));
		endcase
	endfunction

	function automatic logic [8:0] pick_low(input logic [8:0] hw);
		case ($urandom_range(0, 5))
			0:       return 9'd0;
			1:       return 9'd256;
			default: return (hw > 1) ? 9'($urandom_range(0, hw - 1)) : 9'd0;
		endcase
	endfunction

	// a batch of random events with weighted modes
	task automatic run_batch(input int n, input int w_rx, input int w_wr, input int w_rd,
			input int w_cts, input int w_free, input int w_spare);
		int tot;
		int r;
		logic [2:0] md;
		logic [7:0] db;
		tot = w_rx + w_wr + w_rd + w_cts + w_free + w_spare;
		repeat (n) begin
			r = $urandom_range(0, tot - 1);
			if (r < w_rx)
				md = MODE_LINE_RX;
			else if (r < w_rx + w_wr)
				md = MODE_HOST_WR;
			else if (r < w_rx + w_wr + w_rd)
				md = MODE_HOST_RD;
			else if (r < w_rx + w_wr + w_rd + w_cts)
				md = MODE_CTS;
			else if (r < w_rx + w_wr + w_rd + w_cts + w_free)
				md = MODE_TX_FREE;
			else
				md = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
			// flow control characters show up often on purpose
			case ($urandom_range(0, 7))
				0:       db = CHAR_XON;
				1:       db = CHAR_XOFF;
				default: db = 8'($urandom_range(0, 255));
			endcase
			send_event(md, db, 1'($urandom_range(0, 1)), 1'b0, '0);
		end
	endtask

	// ------------------------------------------------------------------
	// result sink: its own stall pattern plus long hold-offs on request
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (holds_done != hold_asks) begin
			holds_done = hold_asks;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			// long hold: the block fills up and drops in_ready
			out_ready = 1'b0;
			hold_left--;
		end else begin
			if (seg_left == 0) begin
				seg_on   = !seg_on;
				seg_left = seg_on ? $urandom_range(1, 40) : $urandom_range(1, 6);
			end
			out_ready = seg_on;
			seg_left--;
		end
	end

	// ------------------------------------------------------------------
	// checker: every accepted result beat against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_beat
		uart_beat_t got;
		uart_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {tx_valid, tx_byte, rts_level, read_valid, read_byte, underflow,
				write_full, rx_overflow, output_blocked, input_blocked, rx_count};
			if (due_status.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("result beat with nothing predicted: %s", beat_str(got));
			end else begin
				want = due_status.pop_front();
				if (got !== want) begin
					fault_count++;
					if (fault_count <= 10)
						$display("result mismatch at %0t\n  want %s\n  got  %s", $realtime,
							beat_str(want), beat_str(got));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		int rounds;
		logic [8:0] hw;

		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		mode      = MODE_LINE_RX;
		data_byte = '0;
		cts_level = 1'b1;

		// directed table; typed beats only where they follow from reset directly
		dir_tab = '{
			// empty read and idle transmitter straight after reset
			ev_known(MODE_HOST_RD, 8'h00, 1'b0, status_of(0, 0, 1, 0, 0, 1, 0, 0, 0, 0, 0)),
			ev_known(MODE_TX_FREE, 8'h00, 1'b0, status_of(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0)),
			// ignored modes report status only
			ev_known(MODE_SPARE_LO, 8'hA5, 1'b1, status_of(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0)),
			ev_known(MODE_SPARE_HI, 8'h5A, 1'b0, status_of(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0)),
			// data extremes; xon is plain data while in-band control is off
			ev_known(MODE_LINE_RX, 8'h00, 1'b0, status_of(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1)),
			ev_known(MODE_LINE_RX, 8'hFF, 1'b1, status_of(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 2)),
			ev_known(MODE_LINE_RX, CHAR_XON, 1'b0, status_of(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 3)),
			ev_known(MODE_HOST_WR, 8'hFF, 1'b0, status_of(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 3)),
			ev_known(MODE_HOST_WR, 8'h00, 1'b1, status_of(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 3)),
			ev_known(MODE_TX_FREE, 8'h00, 1'b0,
				status_of(1, 8'hFF, 1, 0, 0, 0, 0, 0, 0, 0, 3)),
			// cts drop with rts/cts off is only remembered
			ev_known(MODE_CTS, 8'h00, 1'b0, status_of(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 3)),
			ev_known(MODE_HOST_RD, 8'h00, 1'b0,
				status_of(0, 0, 1, 1, 8'h00, 0, 0, 0, 0, 0, 2)),
			ev_known(MODE_HOST_RD, 8'h00, 1'b0,
				status_of(0, 0, 1, 1, 8'hFF, 0, 0, 0, 0, 0, 1)),
			// tight watermarks, both schemes on; cts hold follows the stored low level
			reg_row(REG_HIGH_WATER, 9'd2),
			reg_row(REG_LOW_WATER, 9'd1),
			reg_row(REG_XON_XOFF_EN, 9'd1),
			reg_row(REG_RTS_CTS_EN, 9'd1),
			ev_model(MODE_LINE_RX, 8'hAA, 1'b0),
			// pending xoff leaves although output is held
			ev_model(MODE_TX_FREE, 8'h00, 1'b0),
			ev_model(MODE_LINE_RX, CHAR_XOFF, 1'b0),
			ev_model(MODE_CTS, 8'h00, 1'b1),
			ev_model(MODE_LINE_RX, CHAR_XON, 1'b1),
			ev_model(MODE_TX_FREE, 8'h00, 1'b0),
			// read down to low water queues an xon and raises rts
			ev_model(MODE_HOST_RD, 8'h00, 1'b0),
			ev_model(MODE_TX_FREE, 8'h00, 1'b0),
			ev_model(MODE_SPARE_MID, 8'hFF, 1'b1),
			// high water reached a second time
			ev_model(MODE_LINE_RX, 8'h55, 1'b0),
			// disabling in-band control cancels the pending xoff
			reg_row(REG_XON_XOFF_EN, 9'd0),
			ev_model(MODE_TX_FREE, 8'h00, 1'b0),
			reg_row(REG_RTS_CTS_EN, 9'd0),
			ev_model(MODE_CTS, 8'h00, 1'b0)
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_tab[i].is_reg) begin
				drain_wait();
				reg_write(dir_tab[i].ridx, dir_tab[i].rval);
			end else begin
				send_event(dir_tab[i].md, dir_tab[i].db, dir_tab[i].cl, dir_tab[i].known,
					dir_tab[i].want);
			end
		end

		// watermark churn: frequent xoff/xon and rts drop/raise
		set_config(1'b1, 1'b1, 9'($urandom_range(4, 20)), 9'($urandom_range(0, 3)));
		run_batch(100, 45, 5, 30, 8, 10, 2);

		// receive flood under a long sink hold-off: input stalls, queue overflows,
		// and with rts/cts on, high water at full depth fires on the last free entry
		set_config(1'b0, 1'($urandom_range(0, 1)), 9'd256, 9'($urandom_range(0, 255)));
		hold_asks++;
		run_batch(320, 96, 1, 1, 1, 0, 1);

		// rts/cts re-enabled with the flooded queue checked against the full-depth high water
		drain_wait();
		reg_write(REG_RTS_CTS_EN, 9'd0);
		reg_write(REG_RTS_CTS_EN, 9'd1);

		// drain to empty and beyond: low-water release, then underflow
		set_config(1'b1, 1'b1, 9'd255, 9'($urandom_range(0, 200)));
		run_batch(320, 3, 2, 90, 2, 2, 1);

		// fill the transmit queue until host writes are refused
		set_config(1'b1, 1'b0, 9'($urandom_range(2, 12)), 9'($urandom_range(0, 1)));
		run_batch(300, 2, 93, 2, 1, 1, 1);
		// watermark cycling with the transmit queue full drops the xon
		run_batch(100, 50, 5, 40, 3, 0, 2);

		// transmit drain with cts and in-band holds coming and going
		hw = 9'($urandom_range(2, 16));
		set_config(1'($urandom_range(0, 1)), 1'b1, hw, pick_low(hw));
		run_batch(250, 15, 5, 5, 15, 58, 2);

		// free mix under random settings until the item budget is spent
		rounds = 0;
		while (items_sent < ITEM_TARGET || rounds < 2) begin
			hw = pick_high();
			set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), hw,
				pick_low(hw));
			run_batch($urandom_range(40, 100), 30, 15, 25, 10, 18, 2);
			rounds++;
		end

		drain_wait();
		repeat (8) @(negedge clk);
		if (fault_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
